### hdl/srwl_pkg.sv
// Shared constants, codes and helpers for the scanline register-write list.
// No dependencies; imported by the top level and its port checker.
package srwl_pkg;

    localparam int TABLE_LINES     = 16;
    localparam int WRITES_PER_LINE = 8;

    localparam int TABLE_DEPTH = TABLE_LINES * WRITES_PER_LINE;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int LINE_W      = (TABLE_LINES > 1) ? $clog2(TABLE_LINES) : 1;
    localparam int CNT_W       = $clog2(WRITES_PER_LINE + 1);

    localparam logic [7:0] EMPTY_REG          = 8'hff;
    localparam logic [7:0] CHIP_BIT           = 8'h80;
    localparam logic [7:0] OFFSET_MASK        = 8'h1f;
    localparam logic [4:0] ACTIVE_LINES_RESET = 5'd16;

    localparam logic [1:0] ACT_CLEAR   = 2'd0;
    localparam logic [1:0] ACT_APPEND  = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;
    localparam logic [1:0] ACT_LINE    = 2'd3;

    function automatic logic [ADDR_W-1:0] row_base(input logic [LINE_W-1:0] line);
        return ADDR_W'(int'(line) * WRITES_PER_LINE);
    endfunction

endpackage

### hdl/scanline_register_write_list.sv
// Scanline register-write list: microcoded sequencer, per-line fill counts
// and the write-list memory. Depends on srwl_pkg.
//
// Usage:
//   A request is taken at a rising edge with start high and busy low; the
//   action, line_slot, reg_code and write_value ports are sampled there.
//   cfg_we writes cfg_data into active_lines; write only while idle.
//   Clear, append and restart keep busy high for one cycle and give no result.
//   A line event keeps busy high through a wrap step, a load step and max(n, 1)
//   emit steps, n being the pairs stored for the current line (at most
//   WRITES_PER_LINE). Results come one per cycle, the first after the wrap,
//   load and emit steps, each marked by result_strobe for one cycle; last
//   flags the final one. An empty line gives a single result with write_enable low.
//   The rate is set by the single read port of the list memory: one stored
//   pair per cycle plus a wrap step and a load step per line event.
//   The receiver cannot stall; results are not held.
//   Reset (rst_n low) empties every list through the fill counts, zeroes
//   the line counter and sets active_lines to 16.
module scanline_register_write_list (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] action,
    input  logic [7:0] line_slot,
    input  logic [7:0] reg_code,
    input  logic [7:0] write_value,
    input  logic       cfg_we,
    input  logic [4:0] cfg_data,
    output logic       result_strobe,
    output logic       write_enable,
    output logic       chip_select,
    output logic [4:0] reg_offset,
    output logic [7:0] reg_data,
    output logic       last
);
    import srwl_pkg::*;

    typedef enum logic [2:0] {
        OP_NONE, OP_CLEAR, OP_APPEND, OP_RESTART, OP_WRAP, OP_LOAD, OP_EMIT
    } op_t;

    typedef enum logic [1:0] {
        JMP_SEQ, JMP_GOTO, JMP_DISPATCH, JMP_UNTIL_DONE
    } jmp_t;

    typedef struct packed {
        op_t        op;
        jmp_t       jmp;
        logic [2:0] target;
        logic       busy;
    } ucode_t;

    localparam logic [2:0] STEP_FETCH   = 3'd0;
    localparam logic [2:0] STEP_CLEAR   = 3'd1;
    localparam logic [2:0] STEP_APPEND  = 3'd2;
    localparam logic [2:0] STEP_RESTART = 3'd3;
    localparam logic [2:0] STEP_WRAP    = 3'd4;
    localparam logic [2:0] STEP_LOAD    = 3'd5;
    localparam logic [2:0] STEP_EMIT    = 3'd6;

    // dispatch lands on STEP_CLEAR + action
    function automatic ucode_t ucode_rom(input logic [2:0] step);
        ucode_t w;
        unique case (step)
            STEP_FETCH:   w = '{OP_NONE,    JMP_DISPATCH,   STEP_FETCH, 1'b0};
            STEP_CLEAR:   w = '{OP_CLEAR,   JMP_GOTO,       STEP_FETCH, 1'b1};
            STEP_APPEND:  w = '{OP_APPEND,  JMP_GOTO,       STEP_FETCH, 1'b1};
            STEP_RESTART: w = '{OP_RESTART, JMP_GOTO,       STEP_FETCH, 1'b1};
            STEP_WRAP:    w = '{OP_WRAP,    JMP_SEQ,        STEP_FETCH, 1'b1};
            STEP_LOAD:    w = '{OP_LOAD,    JMP_SEQ,        STEP_FETCH, 1'b1};
            STEP_EMIT:    w = '{OP_EMIT,    JMP_UNTIL_DONE, STEP_FETCH, 1'b1};
            default:      w = '{OP_NONE,    JMP_GOTO,       STEP_FETCH, 1'b1};
        endcase
        return w;
    endfunction

    ucode_t uw;

    logic [2:0]       upc_reg, upc_next;
    logic [7:0]       counter_reg, counter_next;
    logic [4:0]       active_reg, active_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] fill_reg [TABLE_LINES];
    logic [CNT_W-1:0] fill_next [TABLE_LINES];
    logic [7:0]       slot_reg, slot_next;
    logic [7:0]       code_reg, code_next;
    logic [7:0]       value_reg, value_next;

    logic             strobe_reg, strobe_next;
    logic             we_reg, we_next;
    logic             cs_reg, cs_next;
    logic [4:0]       off_reg, off_next;
    logic [7:0]       data_reg, data_next;
    logic             last_reg, last_next;

    logic [15:0]       wlist_mem [TABLE_DEPTH];
    logic [15:0]       rdata_reg;
    logic              mem_we, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;

    logic [LINE_W-1:0] fill_sel;
    logic [CNT_W-1:0]  fill_rd;
    logic [CNT_W-1:0]  idx_inc;
    logic              slot_ok, line_ok, emit_done;

    assign uw       = ucode_rom(upc_reg);
    assign busy     = uw.busy;
    assign fill_sel = (uw.op == OP_APPEND) ? slot_reg[LINE_W-1:0] : counter_reg[LINE_W-1:0];
    assign fill_rd  = fill_reg[fill_sel];
    assign slot_ok  = {1'b0, slot_reg} < 9'(TABLE_LINES);
    assign line_ok  = {1'b0, counter_reg} < 9'(TABLE_LINES);
    assign idx_inc  = idx_reg + 1'b1;
    assign emit_done = (len_reg == '0) || (idx_inc == len_reg);

    always_comb
    begin
        unique case (uw.jmp)
            JMP_SEQ:        upc_next = upc_reg + 3'd1;
            JMP_GOTO:       upc_next = uw.target;
            JMP_DISPATCH:   upc_next = start ? STEP_CLEAR + {1'b0, action} : upc_reg;
            JMP_UNTIL_DONE: upc_next = emit_done ? uw.target : upc_reg;
        endcase
    end

    always_comb
    begin
        counter_next = counter_reg;
        active_next  = cfg_we ? cfg_data : active_reg;
        len_next     = len_reg;
        idx_next     = idx_reg;
        fill_next    = fill_reg;
        slot_next    = slot_reg;
        code_next    = code_reg;
        value_next   = value_reg;
        strobe_next  = 1'b0;
        we_next      = we_reg;
        cs_next      = cs_reg;
        off_next     = off_reg;
        data_next    = data_reg;
        last_next    = last_reg;
        mem_we       = 1'b0;
        wr_addr      = row_base(slot_reg[LINE_W-1:0]) + ADDR_W'(fill_rd);
        rd_en        = 1'b0;
        rd_addr      = row_base(counter_reg[LINE_W-1:0]) + ADDR_W'(idx_inc);

        unique case (uw.op)
            OP_NONE:
            begin
                if (start)
                begin
                    slot_next  = line_slot;
                    code_next  = reg_code;
                    value_next = write_value;
                end
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < TABLE_LINES; i++)
                begin
                    fill_next[i] = '0;
                end
                counter_next = '0;
            end
            OP_APPEND:
            begin
                // an end code leaves the slot empty
                if (slot_ok && fill_rd < CNT_W'(WRITES_PER_LINE) && code_reg != EMPTY_REG)
                begin
                    mem_we                          = 1'b1;
                    fill_next[slot_reg[LINE_W-1:0]] = fill_rd + 1'b1;
                end
            end
            OP_RESTART:
            begin
                counter_next = '0;
            end
            OP_WRAP:
            begin
                if (counter_reg >= {3'b000, active_reg})
                begin
                    counter_next = '0;
                end
            end
            OP_LOAD:
            begin
                len_next = line_ok ? fill_rd : '0;
                idx_next = '0;
                rd_en    = line_ok;
                rd_addr  = row_base(counter_reg[LINE_W-1:0]);
            end
            OP_EMIT:
            begin
                strobe_next = 1'b1;
                if (len_reg == '0)
                begin
                    we_next   = 1'b0;
                    cs_next   = 1'b0;
                    off_next  = '0;
                    data_next = '0;
                end
                else
                begin
                    we_next   = 1'b1;
                    cs_next   = (rdata_reg[15:8] & CHIP_BIT) != 8'h00;
                    off_next  = 5'(rdata_reg[15:8] & OFFSET_MASK);
                    data_next = rdata_reg[7:0];
                end
                last_next = emit_done;
                idx_next  = idx_inc;
                rd_en     = !emit_done;
                if (emit_done)
                begin
                    counter_next = counter_reg + 8'd1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg     <= STEP_FETCH;
            counter_reg <= '0;
            active_reg  <= ACTIVE_LINES_RESET;
            strobe_reg  <= 1'b0;
            for (int i = 0; i < TABLE_LINES; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            upc_reg     <= upc_next;
            counter_reg <= counter_next;
            active_reg  <= active_next;
            strobe_reg  <= strobe_next;
            fill_reg    <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg   <= len_next;
        idx_reg   <= idx_next;
        slot_reg  <= slot_next;
        code_reg  <= code_next;
        value_reg <= value_next;
        we_reg    <= we_next;
        cs_reg    <= cs_next;
        off_reg   <= off_next;
        data_reg  <= data_next;
        last_reg  <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            wlist_mem[wr_addr] <= {code_reg, value_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= wlist_mem[rd_addr];
        end
    end

    assign result_strobe = strobe_reg;
    assign write_enable  = we_reg;
    assign chip_select   = cs_reg;
    assign reg_offset    = off_reg;
    assign reg_data      = data_reg;
    assign last          = last_reg;

endmodule

### hdl/srwl_checker.sv
// Port-level checks for scanline_register_write_list, attached by bind.
// Depends on srwl_pkg for the action codes.
module srwl_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] action,
    input logic       result_strobe,
    input logic       write_enable,
    input logic       chip_select,
    input logic [4:0] reg_offset,
    input logic [7:0] reg_data,
    input logic       last
);
    import srwl_pkg::*;

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !write_enable |-> last && !chip_select
            && reg_offset == 5'd0 && reg_data == 8'd0)
        else $error("empty-line result not all zero with last");

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after request");

    a_no_result_non_line: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && action != ACT_LINE |=> !result_strobe)
        else $error("result after a request that gives none");

    a_more_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !last |-> busy)
        else $error("non-final result while idle");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && last |=> !result_strobe)
        else $error("result right after the final one");

endmodule

bind scanline_register_write_list srwl_checker u_srwl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .result_strobe (result_strobe),
    .write_enable  (write_enable),
    .chip_select   (chip_select),
    .reg_offset    (reg_offset),
    .reg_data      (reg_data),
    .last          (last)
);

### test/tb.sv
// Testbench for scanline_register_write_list: a table of directed requests, then
// random requests under several active_lines settings, checked against a predictor.
// Depends on srwl_pkg and the scanline_register_write_list RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srwl_pkg::*;

    typedef struct packed {
        logic       we;
        logic       cs;
        logic [4:0] offset;
        logic [7:0] data;
        logic       last;
    } write_result_t;

    typedef struct packed {
        logic [1:0]    act;
        logic [7:0]    slot;
        logic [7:0]    code;
        logic [7:0]    value;
        logic          typed;
        write_result_t want;
    } stim_row_t;

    localparam write_result_t NO_WRITES = '{1'b0, 1'b0, 5'd0, 8'd0, 1'b1};
    localparam int DIRECTED_ROWS = 24;
    localparam int PHASES = 7;
    localparam int PHASE_REQUESTS = 53;

    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{ACT_LINE,    8'd0,   8'h00, 8'h00, 1'b1, NO_WRITES},
        '{ACT_RESTART, 8'd0,   8'h00, 8'h00, 1'b0, NO_WRITES},
        '{ACT_APPEND,  8'd0,   8'h9f, 8'hff, 1'b0, NO_WRITES},
        '{ACT_APPEND,  8'd0,   8'h00, 8'h00, 1'b0, NO_WRITES},
        '{ACT_APPEND,  8'd0,   8'hff, 8'h55, 1'b0, NO_WRITES},
        '{ACT_APPEND,  8'd0,   8'h7f, 8'ha5, 1'b0, NO_WRITES},
        '{ACT_APPEND,  8'd16,  8'h01, 8'h01, 1'b0, NO_WRITES},
        '{ACT_APPEND,  8'd255, 8'h02, 8'h02, 1'b0, NO_WRITES},
        '{ACT_LINE,    8'd0,   8'h00, 8'h00, 1'b0, NO_WRITES},
        '{ACT_APPEND,  8'd1,   8'h80, 8'h11, 1'b0, NO_WRITES},
        '{ACT_APPEND,  8'd1,   8'h01, 8'h22, 1'b0, NO_WRITES},
        '{ACT_APPEND,  8'd1,   8'h9e, 8'h33, 1'b0, NO_WRITES},
        '{ACT_APPEND,  8'd1,   8'h1f, 8'h44, 1'b0, NO_WRITES},
        '{ACT_APPEND,  8'd1,   8'he0, 8'h55, 1'b0, NO_WRITES},
        '{ACT_APPEND,  8'd1,   8'h60, 8'h66, 1'b0, NO_WRITES},
        '{ACT_APPEND,  8'd1,   8'h8a, 8'h77, 1'b0, NO_WRITES},
        '{ACT_APPEND,  8'd1,   8'h15, 8'h88, 1'b0, NO_WRITES},
        '{ACT_APPEND,  8'd1,   8'h3c, 8'h99, 1'b0, NO_WRITES},
        '{ACT_LINE,    8'd0,   8'h00, 8'h00, 1'b0, NO_WRITES},
        '{ACT_APPEND,  8'd15,  8'h80, 8'h00, 1'b0, NO_WRITES},
        '{ACT_LINE,    8'd0,   8'h00, 8'h00, 1'b1, NO_WRITES},
        '{ACT_CLEAR,   8'd0,   8'h00, 8'h00, 1'b0, NO_WRITES},
        '{ACT_LINE,    8'd0,   8'h00, 8'h00, 1'b1, NO_WRITES},
        '{ACT_RESTART, 8'd0,   8'h00, 8'h00, 1'b0, NO_WRITES}
    };

    localparam logic [4:0] PHASE_LINES [PHASES] = '{5'd0, 5'd31, 5'd1, 5'd17, 5'd16, 5'd9, 5'd4};

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [1:0] action = ACT_CLEAR;
    logic [7:0] line_slot = 8'd0;
    logic [7:0] reg_code = 8'd0;
    logic [7:0] write_value = 8'd0;
    logic       cfg_we = 1'b0;
    logic [4:0] cfg_data = 5'd0;
    logic       result_strobe;
    logic       write_enable;
    logic       chip_select;
    logic [4:0] reg_offset;
    logic [7:0] reg_data;
    logic       last;

    logic [7:0] list_reg [TABLE_LINES][WRITES_PER_LINE];
    logic [7:0] list_val [TABLE_LINES][WRITES_PER_LINE];
    logic [7:0] line_count;
    logic [4:0] active_lines_cfg;

    write_result_t line_writes[$];
    write_result_t expected_writes[$];
    int error_count = 0;

    scanline_register_write_list u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .line_slot     (line_slot),
        .reg_code      (reg_code),
        .write_value   (write_value),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .result_strobe (result_strobe),
        .write_enable  (write_enable),
        .chip_select   (chip_select),
        .reg_offset    (reg_offset),
        .reg_data      (reg_data),
        .last          (last)
    );

    always #2 clk = ~clk;

    function automatic void empty_all_lists();
        for (int i = 0; i < TABLE_LINES; i++)
        begin
            for (int j = 0; j < WRITES_PER_LINE; j++)
            begin
                list_reg[i][j] = EMPTY_REG;
                list_val[i][j] = 8'd0;
            end
        end
    endfunction

    // Updates the predicted state and leaves the writes of a line event in line_writes.
    function automatic void apply_request(input logic [1:0] act, input logic [7:0] slot,
                                          input logic [7:0] code, input logic [7:0] value);
        bit            done;
        write_result_t w;
        done = 1'b0;
        line_writes.delete();
        case (act)
            ACT_CLEAR:
            begin
                empty_all_lists();
                line_count = 8'd0;
            end
            ACT_APPEND:
            begin
                if (int'(slot) < TABLE_LINES)
                begin
                    for (int j = 0; j < WRITES_PER_LINE; j++)
                    begin
                        if (!done && list_reg[slot][j] == EMPTY_REG)
                        begin
                            list_reg[slot][j] = code;
                            list_val[slot][j] = value;
                            done = 1'b1;
                        end
                    end
                end
            end
            ACT_RESTART:
                line_count = 8'd0;
            default:
            begin
                if (line_count >= active_lines_cfg)
                    line_count = 8'd0;
                if (int'(line_count) < TABLE_LINES)
                begin
                    for (int j = 0; j < WRITES_PER_LINE; j++)
                    begin
                        if (!done && list_reg[line_count][j] == EMPTY_REG)
                            done = 1'b1;
                        if (!done)
                        begin
                            w.we     = 1'b1;
                            w.cs     = (list_reg[line_count][j] & CHIP_BIT) != 8'd0;
                            w.offset = 5'(list_reg[line_count][j] & OFFSET_MASK);
                            w.data   = list_val[line_count][j];
                            w.last   = 1'b0;
                            line_writes.push_back(w);
                        end
                    end
                end
                if (line_writes.size() == 0)
                    line_writes.push_back(NO_WRITES);
                else
                begin
                    w = line_writes.pop_back();
                    w.last = 1'b1;
                    line_writes.push_back(w);
                end
                line_count = line_count + 8'd1;
            end
        endcase
    endfunction

    task automatic send_request(input logic [1:0] act, input logic [7:0] slot,
                                input logic [7:0] code, input logic [7:0] value);
        start       <= 1'b1;
        action      <= act;
        line_slot   <= slot;
        reg_code    <= code;
        write_value <= value;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic pause_requests(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic take_line_writes();
        while (line_writes.size() > 0)
            expected_writes.push_back(line_writes.pop_front());
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (expected_writes.size() != 0)
            @(posedge clk);
        // requests without results may still be in flight
        repeat (4) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic set_active_lines(input logic [4:0] lines);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= lines;
        @(posedge clk);
        cfg_we <= 1'b0;
        active_lines_cfg = lines;
    endtask

    task automatic random_phase(input int count);
        int         burst;
        int         pick;
        int         span;
        logic [1:0] act;
        logic [7:0] slot;
        logic [7:0] code;
        burst = 0;
        for (int i = 0; i < count; i++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 12);
                pause_requests(($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6));
            end
            pick = $urandom_range(99);
            if (pick < 3)
                act = ACT_CLEAR;
            else if (pick < 10)
                act = ACT_RESTART;
            else if (pick < 55)
                act = ACT_APPEND;
            else
                act = ACT_LINE;
            span = (active_lines_cfg == 0) ? 1 :
                   (int'(active_lines_cfg) > TABLE_LINES) ? TABLE_LINES : int'(active_lines_cfg);
            pick = $urandom_range(9);
            if (pick < 2)
                slot = 8'($urandom_range(255));
            else if (pick < 6)
                slot = 8'($urandom_range(span - 1));
            else
                slot = 8'($urandom_range(TABLE_LINES - 1));
            code = ($urandom_range(19) == 0) ? EMPTY_REG : 8'($urandom_range(255));
            send_request(act, slot, code, 8'($urandom_range(255)));
            apply_request(act, slot, code, write_value);
            take_line_writes();
            burst--;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        write_result_t want;
        if (rst_n && result_strobe)
        begin
            if (expected_writes.size() == 0)
            begin
                $error("result with no request pending");
                error_count++;
            end
            else
            begin
                want = expected_writes.pop_front();
                if (write_enable !== want.we)
                begin
                    $error("write_enable: expected %0d, got %0d", want.we, write_enable);
                    error_count++;
                end
                if (chip_select !== want.cs)
                begin
                    $error("chip_select: expected %0d, got %0d", want.cs, chip_select);
                    error_count++;
                end
                if (reg_offset !== want.offset)
                begin
                    $error("reg_offset: expected %0d, got %0d", want.offset, reg_offset);
                    error_count++;
                end
                if (reg_data !== want.data)
                begin
                    $error("reg_data: expected 0x%02h, got 0x%02h", want.data, reg_data);
                    error_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, last);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #1000000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        logic [4:0] lines;
        empty_all_lists();
        line_count = 8'd0;
        active_lines_cfg = ACTIVE_LINES_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            pause_requests(($urandom_range(2) == 0) ? $urandom_range(1, 3) : 0);
            send_request(DIRECTED[r].act, DIRECTED[r].slot, DIRECTED[r].code,
                         DIRECTED[r].value);
            apply_request(DIRECTED[r].act, DIRECTED[r].slot, DIRECTED[r].code,
                          DIRECTED[r].value);
            if (DIRECTED[r].typed)
            begin
                line_writes.delete();
                expected_writes.push_back(DIRECTED[r].want);
            end
            else
                take_line_writes();
        end

        for (int p = 0; p < PHASES; p++)
        begin
            lines = (p == 5) ? 5'($urandom_range(31)) : PHASE_LINES[p];
            set_active_lines(lines);
            random_phase(PHASE_REQUESTS);
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### scanline_register_write_list.f
hdl/srwl_pkg.sv
hdl/scanline_register_write_list.sv
hdl/srwl_checker.sv
test/tb.sv
